@@ rtl/flt_pkg.sv @@
// Package for the frame loss tracker: sizes, word types, controller states,
// command and status structs and saturating counter helpers. No dependencies.
`default_nettype none

package flt_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 16;
    localparam int COUNT_BITS  = 32;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int OCC_BITS = $clog2(QUEUE_DEPTH + 1);

    // Counter slots
    localparam int NUM_CNT  = 6;
    localparam int CNT_TX   = 0;
    localparam int CNT_TXU  = 1;
    localparam int CNT_RXG  = 2;
    localparam int CNT_RXB  = 3;
    localparam int CNT_RXU  = 4;
    localparam int CNT_LOST = 5;

    localparam logic MODE_TX = 1'b0;
    localparam logic MODE_RX = 1'b1;

    typedef logic [ID_BITS-1:0]    t_id;
    typedef logic [COUNT_BITS-1:0] t_cnt;
    typedef logic [PTR_BITS-1:0]   t_ptr;
    typedef logic [OCC_BITS-1:0]   t_occ;

    typedef struct packed {
        logic        mode;
        logic [15:0] seq_id;
        logic        id_valid;
        logic        crc_ok;
    } t_in_word;

    typedef struct packed {
        logic        matched;
        logic        restarted;
        logic        overflow;
        logic [4:0]  lost_burst;
        logic [31:0] tx_count;
        logic [31:0] tx_unparsed_count;
        logic [31:0] rx_good_count;
        logic [31:0] rx_bad_count;
        logic [31:0] rx_unparsed_count;
        logic [31:0] lost_count;
        logic [4:0]  pending_count;
    } t_out_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic tx_op;
        logic rx_count;
        logic pop_lost;
        logic pop_match;
        logic add_lost;
    } t_dp_cmd;

    typedef struct packed {
        logic mode;
        logic id_valid;
        logic occ_nz;
        logic head_lt;
        logic head_eq;
    } t_dp_status;

    function automatic t_cnt sat_inc(input t_cnt cur);
        t_cnt res;
        res = (cur == {COUNT_BITS{1'b1}}) ? cur : cur + t_cnt'(1);
        return res;
    endfunction

    function automatic t_cnt sat_add(input t_cnt cur, input t_occ amt);
        logic [COUNT_BITS:0] sum;
        sum = {1'b0, cur} + (COUNT_BITS + 1)'(amt);
        return sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
    endfunction

    function automatic t_ptr ptr_next(input t_ptr p);
        t_ptr res;
        res = (p == t_ptr'(QUEUE_DEPTH - 1)) ? t_ptr'(0) : p + t_ptr'(1);
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/flt_ctrl.sv @@
// Controller of the frame loss tracker: sequences load, update, scan and report.
// Depends on flt_pkg.
`default_nettype none

module flt_ctrl
    import flt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd,
    output logic            busy,
    output logic            o_strobe
);

    t_state r_state;
    t_state n_state;
    logic   scan_more;

    assign scan_more = i_status.occ_nz && i_status.head_lt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (i_status.mode == MODE_TX || !i_status.id_valid) n_state = ST_DONE;
                else n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (!scan_more) n_state = ST_DONE;
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd    = '0;
        busy     = 1'b1;
        o_strobe = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            ST_DECIDE: begin
                o_cmd.tx_op    = (i_status.mode == MODE_TX);
                o_cmd.rx_count = (i_status.mode == MODE_RX);
            end
            ST_SCAN: begin
                o_cmd.pop_lost  = scan_more;
                o_cmd.pop_match = !scan_more && i_status.occ_nz && i_status.head_eq;
                o_cmd.add_lost  = !scan_more;
            end
            ST_DONE: begin
                o_strobe = 1'b1;
            end
            default: begin
                o_strobe = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/flt_dp.sv @@
// Datapath of the frame loss tracker: pending id queue, pointers, counters
// and result registers. Depends on flt_pkg.
`default_nettype none

module flt_dp
    import flt_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_in_word i_word,
    input  wire t_dp_cmd  i_cmd,
    output t_dp_status    o_status,
    output t_out_word     o_word
);

    t_id  r_mem [QUEUE_DEPTH];
    t_id  r_head_data;

    t_ptr r_head, n_head;
    t_ptr r_tail, n_tail;
    t_occ r_occ, n_occ;
    logic r_have_last, n_have_last;
    t_id  r_last_id, n_last_id;
    t_cnt r_cnt [NUM_CNT];
    t_cnt n_cnt [NUM_CNT];

    logic r_mode, r_valid, r_crc;
    t_id  r_id;
    t_occ r_lost, n_lost;
    logic r_matched, n_matched;
    logic r_restarted, n_restarted;
    logic r_overflow, n_overflow;

    logic wr_en;
    t_ptr wr_addr;
    logic restart;
    t_ptr tail_eff;
    t_occ occ_eff;

    assign restart  = r_valid && r_have_last && (r_id <= r_last_id);
    assign tail_eff = restart ? t_ptr'(0) : r_tail;
    assign occ_eff  = restart ? t_occ'(0) : r_occ;

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_occ       = r_occ;
        n_have_last = r_have_last;
        n_last_id   = r_last_id;
        n_cnt       = r_cnt;
        n_lost      = r_lost;
        n_matched   = r_matched;
        n_restarted = r_restarted;
        n_overflow  = r_overflow;
        wr_en       = 1'b0;
        wr_addr     = tail_eff;

        if (i_cmd.load) begin
            n_lost      = '0;
            n_matched   = 1'b0;
            n_restarted = 1'b0;
            n_overflow  = 1'b0;
        end

        if (i_cmd.tx_op) begin
            if (restart) begin
                n_restarted = 1'b1;
                n_head      = '0;
                for (int k = 0; k < NUM_CNT; k++) begin
                    n_cnt[k] = '0;
                end
            end
            n_tail = tail_eff;
            n_occ  = occ_eff;
            n_cnt[CNT_TX] = sat_inc(restart ? t_cnt'(0) : r_cnt[CNT_TX]);
            if (r_valid) begin
                n_have_last = 1'b1;
                n_last_id   = r_id;
                if (occ_eff == t_occ'(QUEUE_DEPTH)) begin
                    n_overflow = 1'b1;
                end else begin
                    wr_en  = 1'b1;
                    n_tail = ptr_next(tail_eff);
                    n_occ  = occ_eff + t_occ'(1);
                end
            end else begin
                n_cnt[CNT_TXU] = sat_inc(r_cnt[CNT_TXU]);
            end
        end

        if (i_cmd.rx_count) begin
            if (r_crc) n_cnt[CNT_RXG] = sat_inc(r_cnt[CNT_RXG]);
            else       n_cnt[CNT_RXB] = sat_inc(r_cnt[CNT_RXB]);
            if (!r_valid) n_cnt[CNT_RXU] = sat_inc(r_cnt[CNT_RXU]);
        end

        if (i_cmd.pop_lost || i_cmd.pop_match) begin
            n_head = ptr_next(r_head);
            n_occ  = r_occ - t_occ'(1);
        end
        if (i_cmd.pop_lost)  n_lost    = r_lost + t_occ'(1);
        if (i_cmd.pop_match) n_matched = 1'b1;
        if (i_cmd.add_lost)  n_cnt[CNT_LOST] = sat_add(r_cnt[CNT_LOST], r_lost);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_occ       <= '0;
            r_have_last <= 1'b0;
            r_last_id   <= '0;
            for (int k = 0; k < NUM_CNT; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_occ       <= n_occ;
            r_have_last <= n_have_last;
            r_last_id   <= n_last_id;
            r_cnt       <= n_cnt;
        end
    end

    // Input capture and per-word result flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_word.mode;
            r_id    <= i_word.seq_id[ID_BITS-1:0];
            r_valid <= i_word.id_valid;
            r_crc   <= i_word.crc_ok;
        end
        r_lost      <= n_lost;
        r_matched   <= n_matched;
        r_restarted <= n_restarted;
        r_overflow  <= n_overflow;
    end

    // Queue store, with head read at the next head address and write bypass
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && wr_addr == n_head) begin
            r_head_data <= r_id;
        end else begin
            r_head_data <= r_mem[n_head];
        end
    end

    assign o_status.mode     = r_mode;
    assign o_status.id_valid = r_valid;
    assign o_status.occ_nz   = (r_occ != '0);
    assign o_status.head_lt  = (r_head_data < r_id);
    assign o_status.head_eq  = (r_head_data == r_id);

    assign o_word.matched           = r_matched;
    assign o_word.restarted         = r_restarted;
    assign o_word.overflow          = r_overflow;
    assign o_word.lost_burst        = r_lost;
    assign o_word.tx_count          = r_cnt[CNT_TX];
    assign o_word.tx_unparsed_count = r_cnt[CNT_TXU];
    assign o_word.rx_good_count     = r_cnt[CNT_RXG];
    assign o_word.rx_bad_count      = r_cnt[CNT_RXB];
    assign o_word.rx_unparsed_count = r_cnt[CNT_RXU];
    assign o_word.lost_count        = r_cnt[CNT_LOST];
    assign o_word.pending_count     = r_occ;

endmodule

`default_nettype wire

@@ rtl/frame_loss_tracker.sv @@
// Frame loss tracker: one result word per event word, shown for one cycle on o_strobe.
// Transmit event or event without a valid id: accept, the decide state, then the report.
// Receive event with id: accept, the decide state, a scan of the queue head, then the report;
// the scan pops one queue entry per cycle and drops up to 16 pending ids as lost.
// Synchronous active-low reset empties the queue and clears all counters.
// The receiver cannot stall; busy stays high from accept until the strobe cycle ends.
`default_nettype none

module frame_loss_tracker
    import flt_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    input  wire t_in_word i_word,
    output logic          busy,
    output logic          o_strobe,
    output t_out_word     o_word
);

    // Commands from the controller, status back from the datapath
    t_dp_cmd    cmd;
    t_dp_status status;

    // Sequence: accept word, update queue and counters, scan the head, report
    flt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy),
        .o_strobe (o_strobe)
    );

    // Hold the pending queue, pointers and saturating counters
    flt_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_word   (i_word),
        .i_cmd    (cmd),
        .o_status (status),
        .o_word   (o_word)
    );

endmodule

`default_nettype wire
